FILE: rtl/scba_pkg.sv
// Shared types and constants for the size-class block allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
package scba_pkg;

  localparam int MaxClasses = 11;
  localparam int GranBits   = 13;

  // Block size of each class in bytes, header included.
  localparam logic [15:0] ClassBytes [MaxClasses] = '{
    16'd16, 16'd32, 16'd64, 16'd128, 16'd256, 16'd1024,
    16'd2048, 16'd4096, 16'd8192, 16'd16384, 16'd32704
  };

  // Header word layout.
  localparam int HdrValidBit  = 31;
  localparam int LinkValidBit = 30;
  localparam int LinkBits     = 15;
  localparam int CountBits    = 16;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_ADDREF = 2'd2,
    OP_NONE   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    STS_OK          = 3'd0,
    STS_TOO_LARGE   = 3'd1,
    STS_EXHAUSTED   = 3'd2,
    STS_NOT_ALLOC   = 3'd3,
    STS_REFS_REMAIN = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } ctl_state_e;

  typedef struct packed {
    logic clear;
    logic load;
    logic lookup;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
  } sts_t;

endpackage

FILE: rtl/scba_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Standalone; no package needed.
module scba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/scba_ctrl.sv
// Controller state machine of the allocator: clearing pass, lookup and update steps.
// Depends on scba_pkg for the state type and the command and status structs.
module scba_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  scba_pkg::sts_t sts_i,
  output scba_pkg::cmd_t cmd_o
);

  scba_pkg::ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= scba_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      scba_pkg::ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = scba_pkg::ST_IDLE;
        end
      end
      scba_pkg::ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = scba_pkg::ST_LOOKUP;
        end
      end
      scba_pkg::ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d      = scba_pkg::ST_UPDATE;
      end
      scba_pkg::ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = scba_pkg::ST_IDLE;
      end
      default: begin
        state_d = scba_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state_q != scba_pkg::ST_IDLE);

endmodule

FILE: rtl/scba_dpath.sv
// Datapath of the allocator: request registers, class pick, free-list heads,
// bump pointer, header memory and result registers. Depends on scba_pkg and scba_ram.
module scba_dpath #(
  parameter int HEAP_BYTES  = 131072,
  parameter int NUM_CLASSES = 11
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  scba_pkg::cmd_t cmd_i,
  output scba_pkg::sts_t sts_o,
  input  logic [1:0]     req_type_i,
  input  logic [15:0]    request_size_i,
  input  logic [16:0]    payload_address_i,
  output logic           result_valid_o,
  output logic [16:0]    result_address_o,
  output logic [2:0]     status_o,
  output logic [15:0]    ref_count_o
);

  localparam int Granules = HEAP_BYTES / 8;
  localparam int GW       = $clog2(Granules);
  localparam int CW       = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  // The bump sum must hold both the pointer and the largest class in granules,
  // even when a class is bigger than a small heap.
  localparam int SW       = ((GW > scba_pkg::GranBits) ? GW : scba_pkg::GranBits) + 2;

  // Request registers.
  scba_pkg::req_e req_q;
  logic [15:0]    size_q;
  logic [16:0]    addr_q;

  // Values settled in the lookup step.
  logic [CW-1:0]                 cls_d, cls_q;
  logic                          cls_ok_d, cls_ok_q;
  logic [scba_pkg::GranBits-1:0] gran_d, gran_q;
  logic [GW-1:0]                 hdr_d, hdr_q;
  logic                          hdr_ok_d, hdr_ok_q;
  logic [GW-1:0]                 head_q;
  logic                          head_v_q;

  // Allocator state.
  logic [GW-1:0] heads_q      [NUM_CLASSES];
  logic          head_valid_q [NUM_CLASSES];
  logic [GW:0]   bump_q, bump_d;
  logic [GW-1:0] clr_cnt_q;

  // Header memory ports.
  logic          mem_we;
  logic [GW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic [GW-1:0] mem_raddr;
  logic [31:0]   mem_rdata;

  // Update step results.
  logic          head_we;
  logic [GW-1:0] head_wdata;
  logic          head_wvalid;
  logic [16:0]   res_addr_d;
  scba_pkg::status_e res_sts_d;
  logic [15:0]   res_cnt_d;

  logic [16:0]   need;
  logic [13:0]   gnum;
  logic [13:0]   gidx;
  logic [SW-1:0] bump_sum;
  logic [15:0]   cnt;
  logic [GW:0]   blk_p1;
  logic [GW-1:0] blk;

  // Size class pick: smallest enabled class whose size covers payload plus header.
  always_comb begin
    need     = 17'(size_q) + 17'd8;
    cls_d    = '0;
    cls_ok_d = 1'b0;
    gran_d   = '0;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (need <= 17'(scba_pkg::ClassBytes[c])) begin
        cls_d    = CW'(c);
        cls_ok_d = 1'b1;
        gran_d   = scba_pkg::GranBits'(scba_pkg::ClassBytes[c] >> 3);
      end
    end
  end

  // Header granule of the payload address.
  always_comb begin
    gnum     = addr_q[16:3];
    gidx     = gnum - 14'd1;
    hdr_ok_d = (gnum != 14'd0) && (addr_q[2:0] == 3'd0) && (32'(gidx) < 32'(Granules));
    hdr_d    = GW'(gidx);
  end

  assign mem_raddr = (req_q == scba_pkg::OP_ALLOC) ? heads_q[cls_d] : hdr_d;

  assign bump_sum = SW'(bump_q) + SW'(gran_q);
  assign cnt      = mem_rdata[scba_pkg::CountBits-1:0];

  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = hdr_q;
    mem_wdata   = '0;
    head_we     = 1'b0;
    head_wdata  = hdr_q;
    head_wvalid = 1'b1;
    bump_d      = bump_q;
    res_addr_d  = '0;
    res_sts_d   = scba_pkg::STS_OK;
    res_cnt_d   = '0;
    blk         = head_q;
    blk_p1      = '0;

    if (cmd_i.clear) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
    end else if (cmd_i.update) begin
      case (req_q)
        scba_pkg::OP_ALLOC: begin
          if (!cls_ok_q) begin
            res_sts_d = scba_pkg::STS_TOO_LARGE;
          end else if (!head_v_q && (bump_sum > SW'(Granules))) begin
            res_sts_d = scba_pkg::STS_EXHAUSTED;
          end else begin
            if (head_v_q) begin
              // Pop the list: the old head's link becomes the new head.
              blk         = head_q;
              head_we     = 1'b1;
              head_wdata  = GW'(mem_rdata[scba_pkg::LinkBits-1:0]);
              head_wvalid = mem_rdata[scba_pkg::LinkValidBit];
            end else begin
              blk    = GW'(bump_q);
              bump_d = (GW+1)'(bump_sum);
            end
            mem_we     = 1'b1;
            mem_waddr  = blk;
            mem_wdata  = {1'b1, 15'd0, 16'd1};
            blk_p1     = (GW+1)'(blk) + (GW+1)'(1);
            res_addr_d = 17'({blk_p1, 3'b000});
            res_cnt_d  = 16'd1;
          end
        end
        scba_pkg::OP_FREE, scba_pkg::OP_ADDREF: begin
          if (!hdr_ok_q || !mem_rdata[scba_pkg::HdrValidBit]) begin
            res_sts_d = scba_pkg::STS_NOT_ALLOC;
          end else if (req_q == scba_pkg::OP_ADDREF) begin
            res_cnt_d = (cnt == 16'hFFFF) ? cnt : cnt + 16'd1;
            mem_we    = 1'b1;
            mem_wdata = {1'b1, 15'd0, res_cnt_d};
          end else if (cnt > 16'd1) begin
            res_cnt_d = cnt - 16'd1;
            res_sts_d = scba_pkg::STS_REFS_REMAIN;
            mem_we    = 1'b1;
            mem_wdata = {1'b1, 15'd0, res_cnt_d};
          end else if (!cls_ok_q) begin
            res_sts_d = scba_pkg::STS_TOO_LARGE;
          end else begin
            // Push the block onto the list of the class that the size selects.
            mem_we     = 1'b1;
            mem_wdata  = head_v_q ? {2'b01, 15'd0, 15'(head_q)} : 32'd0;
            head_we    = 1'b1;
            head_wdata = hdr_q;
          end
        end
        default: begin
          res_sts_d = scba_pkg::STS_OK;
        end
      endcase
    end
  end

  scba_ram #(
    .WIDTH(32),
    .DEPTH(Granules)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (cmd_i.lookup),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign sts_o.clear_last = (clr_cnt_q == GW'(Granules - 1));

  // Request, lookup, list-head and result registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= scba_pkg::req_e'(req_type_i);
      size_q <= request_size_i;
      addr_q <= payload_address_i;
    end
    if (cmd_i.lookup) begin
      cls_q    <= cls_d;
      cls_ok_q <= cls_ok_d;
      gran_q   <= gran_d;
      hdr_q    <= hdr_d;
      hdr_ok_q <= hdr_ok_d;
      head_q   <= heads_q[cls_d];
    end
    if (head_we) begin
      heads_q[cls_q] <= head_wdata;
    end
    if (cmd_i.update) begin
      result_address_o <= res_addr_d;
      status_o         <= res_sts_d;
      ref_count_o      <= res_cnt_d;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head_valid_q[c] <= 1'b0;
      end
      head_v_q       <= 1'b0;
      bump_q         <= '0;
      clr_cnt_q      <= '0;
      result_valid_o <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        clr_cnt_q <= clr_cnt_q + GW'(1);
      end
      if (cmd_i.lookup) begin
        head_v_q <= head_valid_q[cls_d];
      end
      if (head_we) begin
        head_valid_q[cls_q] <= head_wvalid;
      end
      if (cmd_i.update) begin
        bump_q <= bump_d;
      end
      result_valid_o <= cmd_i.update;
    end
  end

endmodule

FILE: rtl/size_class_block_allocator_top.sv
// Size-class block allocator: eleven block classes, free lists and reference counts.
// A request accepted at an edge goes through the lookup and update steps; the update registers
// the result and raises the result strobe. A new request can be accepted in the cycle that shows
// the strobe, not before: busy stays high through the header read and the header write-back.
// After reset the header memory is cleared, one granule a cycle over all HEAP_BYTES/8 granules
// (16384 by default), with busy high; the result strobe cannot be held off.
module size_class_block_allocator_top #(
  parameter int HEAP_BYTES  = 131072,
  parameter int NUM_CLASSES = 11
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] request_size_i,
  input  logic [16:0] payload_address_i,
  output logic        result_valid_o,
  output logic [16:0] result_address_o,
  output logic [2:0]  status_o,
  output logic [15:0] ref_count_o
);

  scba_pkg::cmd_t cmd;
  scba_pkg::sts_t sts;

  scba_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  scba_dpath #(
    .HEAP_BYTES  (HEAP_BYTES),
    .NUM_CLASSES (NUM_CLASSES)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .req_type_i        (req_type_i),
    .request_size_i    (request_size_i),
    .payload_address_i (payload_address_i),
    .result_valid_o    (result_valid_o),
    .result_address_o  (result_address_o),
    .status_o          (status_o),
    .ref_count_o       (ref_count_o)
  );

endmodule

FILE: bench/size_class_block_allocator_checker.sv
// Checker for the size-class block allocator: watches request and result transactions,
// predicts each result from its own copy of the heap state and compares it field by field.
// Depends on scba_pkg for the request and status codes.
module size_class_block_allocator_checker #(
  parameter int HEAP_BYTES  = 131072,
  parameter int NUM_CLASSES = 11
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] request_size_i,
  input  logic [16:0] payload_address_i,
  input  logic        result_valid_i,
  input  logic [16:0] result_address_i,
  input  logic [2:0]  status_i,
  input  logic [15:0] ref_count_i,
  output int          errors_o,
  output int          outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Granules    = HEAP_BYTES / 8;
  localparam int UsedClasses = (NUM_CLASSES > 11) ? 11 : NUM_CLASSES;
  localparam int BlockBytes [11] = '{16, 32, 64, 128, 256, 1024, 2048, 4096, 8192, 16384,
                                     32704};

  typedef struct {
    logic [16:0]       addr;
    scba_pkg::status_e status;
    logic [15:0]       count;
  } alloc_reply_t;

  // Heap image: one header word per granule, a LIFO list head per class, a bump pointer.
  bit [31:0]    hdr_word [Granules];
  bit [14:0]    list_head [11];
  bit           list_nonempty [11];
  int           bump_gran;
  alloc_reply_t awaited_replies [$];
  alloc_reply_t want;
  int           mismatches;

  function automatic int pick_class(logic [15:0] size);
    int need;
    need = int'(size) + 8;
    for (int c = 0; c < UsedClasses; c++) begin
      if (need <= BlockBytes[c]) return c;
    end
    return -1;
  endfunction

  function automatic alloc_reply_t predict_reply(scba_pkg::req_e op, logic [15:0] size,
                                                 logic [16:0] addr);
    alloc_reply_t r;
    int           cls;
    int           blk;
    int           g;
    bit [31:0]    w;
    logic [15:0]  cnt;
    r = '{addr: '0, status: scba_pkg::STS_OK, count: '0};
    case (op)
      scba_pkg::OP_ALLOC: begin
        cls = pick_class(size);
        if (cls < 0) begin
          r.status = scba_pkg::STS_TOO_LARGE;
          return r;
        end
        if (list_nonempty[cls]) begin
          blk = int'(list_head[cls]) % Granules;
          w = hdr_word[blk];
          if (w[scba_pkg::LinkValidBit]) begin
            list_head[cls] = w[14:0];
          end else begin
            list_head[cls] = '0;
            list_nonempty[cls] = 1'b0;
          end
        end else begin
          if (bump_gran + BlockBytes[cls] / 8 > Granules) begin
            r.status = scba_pkg::STS_EXHAUSTED;
            return r;
          end
          blk = bump_gran;
          bump_gran += BlockBytes[cls] / 8;
        end
        hdr_word[blk] = 32'h8000_0001;
        r.addr  = 17'((blk + 1) * 8);
        r.count = 16'd1;
      end
      scba_pkg::OP_FREE, scba_pkg::OP_ADDREF: begin
        g = int'(addr >> 3) - 1;
        if (addr < 17'd8 || addr[2:0] != 3'd0 || g >= Granules) begin
          r.status = scba_pkg::STS_NOT_ALLOC;
          return r;
        end
        w = hdr_word[g];
        if (!w[scba_pkg::HdrValidBit]) begin
          r.status = scba_pkg::STS_NOT_ALLOC;
          return r;
        end
        cnt = w[15:0];
        if (op == scba_pkg::OP_ADDREF) begin
          if (cnt != 16'hFFFF) cnt++;
          hdr_word[g] = {16'h8000, cnt};
          r.count = cnt;
        end else if (cnt > 16'd1) begin
          cnt--;
          hdr_word[g] = {16'h8000, cnt};
          r.status = scba_pkg::STS_REFS_REMAIN;
          r.count  = cnt;
        end else begin
          // Release: the size given with the free picks the list, not the original one.
          cls = pick_class(size);
          if (cls < 0) begin
            r.status = scba_pkg::STS_TOO_LARGE;
            return r;
          end
          hdr_word[g] = list_nonempty[cls] ? {2'b01, 15'd0, list_head[cls]} : 32'd0;
          list_head[cls] = 15'(g);
          list_nonempty[cls] = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(string name, logic [16:0] exp_v, logic [16:0] act_v);
    if (act_v !== exp_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (hdr_word[i]) hdr_word[i] = '0;
      foreach (list_head[i]) begin
        list_head[i] = '0;
        list_nonempty[i] = 1'b0;
      end
      bump_gran = 0;
      mismatches = 0;
      awaited_replies.delete();
      errors_o <= 0;
      outstanding_o <= 0;
    end else begin
      // Retire the oldest transaction before queueing one accepted at this edge.
      if (result_valid_i) begin
        if (awaited_replies.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual address %0d status %0d count %0d",
                   $time, result_address_i, status_i, ref_count_i);
        end else begin
          want = awaited_replies.pop_front();
          check_field("result_address", want.addr, result_address_i);
          check_field("status", 17'(want.status), 17'(status_i));
          check_field("ref_count", 17'(want.count), 17'(ref_count_i));
        end
      end
      if (start_i && !busy_i) begin
        awaited_replies.push_back(predict_reply(scba_pkg::req_e'(req_type_i), request_size_i,
                                                payload_address_i));
      end
      outstanding_o <= awaited_replies.size();
      errors_o <= mismatches;
    end
  end

endmodule

FILE: bench/size_class_block_allocator_top_tb.sv
// Testbench top for the size-class block allocator: clock, reset, request stimulus and verdict.
// Depends on scba_pkg, size_class_block_allocator_top and size_class_block_allocator_checker.
module size_class_block_allocator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HeapBytes  = 131072;
  localparam int NumClasses = 11;
  localparam int RandomRequests = 1100;

  typedef struct {
    scba_pkg::req_e op;
    logic [15:0]    size;
  } sent_req_t;

  typedef struct {
    logic [16:0] addr;
    logic [15:0] size;
  } live_block_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  req_type;
  logic [15:0] request_size;
  logic [16:0] payload_address;
  logic        result_valid_o;
  logic [16:0] result_address_o;
  logic [2:0]  status_o;
  logic [15:0] ref_count_o;
  int          mismatch_count;
  int          outstanding_count;

  sent_req_t   sent_q [$];
  sent_req_t   done_req;
  live_block_t live_q [$];

  size_class_block_allocator_top #(
    .HEAP_BYTES (HeapBytes),
    .NUM_CLASSES(NumClasses)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .req_type_i       (req_type),
    .request_size_i   (request_size),
    .payload_address_i(payload_address),
    .result_valid_o   (result_valid_o),
    .result_address_o (result_address_o),
    .status_o         (status_o),
    .ref_count_o      (ref_count_o)
  );

  size_class_block_allocator_checker #(
    .HEAP_BYTES (HeapBytes),
    .NUM_CLASSES(NumClasses)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_i           (busy),
    .req_type_i       (req_type),
    .request_size_i   (request_size),
    .payload_address_i(payload_address),
    .result_valid_i   (result_valid_o),
    .result_address_i (result_address_o),
    .status_i         (status_o),
    .ref_count_i      (ref_count_o),
    .errors_o         (mismatch_count),
    .outstanding_o    (outstanding_count)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Remember which addresses came back from successful allocations, so that most
  // frees and reference increments hit live blocks.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o && sent_q.size() > 0) begin
        done_req = sent_q.pop_front();
        if (done_req.op == scba_pkg::OP_ALLOC && status_o == scba_pkg::STS_OK) begin
          live_q.push_back('{addr: result_address_o, size: done_req.size});
          if (live_q.size() > 48) void'(live_q.pop_front());
        end
      end
      if (start && !busy) begin
        sent_q.push_back('{op: scba_pkg::req_e'(req_type), size: request_size});
      end
    end
  end

  task automatic send_request(scba_pkg::req_e op, logic [15:0] sz, logic [16:0] ad);
    @(negedge clk_i);
    start <= 1'b1;
    req_type <= op;
    request_size <= sz;
    payload_address <= ad;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic idle_for(int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      start <= 1'b0;
      req_type <= 2'($urandom);
      request_size <= 16'($urandom);
      payload_address <= 17'($urandom);
    end
  endtask

  task automatic drain_replies();
    idle_for(1);
    while (outstanding_count != 0) @(posedge clk_i);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Mostly small classes so the bump space lasts; a few oversize requests.
  function automatic logic [15:0] random_alloc_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 16'($urandom_range(0, 56));
    if (r < 75) return 16'($urandom_range(57, 248));
    if (r < 90) return 16'($urandom_range(249, 4088));
    if (r < 96) return 16'($urandom_range(4089, 16376));
    if (r < 99) return 16'($urandom_range(16377, 32696));
    return 16'($urandom_range(32697, 65535));
  endfunction

  task automatic issue_random_request();
    int             r;
    int             k;
    scba_pkg::req_e op;
    logic [15:0]    sz;
    logic [16:0]    ad;
    r = $urandom_range(0, 99);
    sz = 16'($urandom);
    ad = 17'($urandom);
    if (r < 45) begin
      op = scba_pkg::OP_ALLOC;
      sz = random_alloc_size();
    end else if (r < 95) begin
      op = (r < 75) ? scba_pkg::OP_FREE : scba_pkg::OP_ADDREF;
      if (live_q.size() > 0 && $urandom_range(0, 99) < 80) begin
        k = $urandom_range(0, live_q.size() - 1);
        ad = live_q[k].addr;
        sz = live_q[k].size;
        if (op == scba_pkg::OP_FREE && $urandom_range(0, 99) < 60) live_q.delete(k);
        // Now and then free into another class than the one allocated.
        if ($urandom_range(0, 99) < 8) sz = random_alloc_size();
      end else if ($urandom_range(0, 1) == 1) begin
        ad = {ad[16:3], 3'b000};
      end
    end else begin
      op = scba_pkg::OP_NONE;
    end
    send_request(op, sz, ad);
    idle_for(pick_gap());
  endtask

  initial begin
    #5_000_000;
    $display("size_class_block_allocator_top_tb: done, errors");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    req_type = scba_pkg::OP_ALLOC;
    request_size = '0;
    payload_address = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: class edges, bad addresses, reference counting and list reuse.
    send_request(scba_pkg::OP_ALLOC, 16'd0, 17'd0);
    send_request(scba_pkg::OP_ALLOC, 16'd8, 17'd0);
    send_request(scba_pkg::OP_ALLOC, 16'd9, 17'd0);
    idle_for(1);
    send_request(scba_pkg::OP_ALLOC, 16'hFFFF, 17'h1FFFF);
    send_request(scba_pkg::OP_ALLOC, 16'd32696, 17'd0);
    send_request(scba_pkg::OP_ALLOC, 16'd32697, 17'd0);
    send_request(scba_pkg::OP_ADDREF, 16'd0, 17'd0);
    idle_for(2);
    send_request(scba_pkg::OP_ADDREF, 16'd0, 17'd12);
    send_request(scba_pkg::OP_FREE, 16'd0, 17'd131064);
    send_request(scba_pkg::OP_ADDREF, 16'd0, 17'h1FFFF);
    send_request(scba_pkg::OP_ADDREF, 16'd0, 17'd8);
    send_request(scba_pkg::OP_FREE, 16'd0, 17'd8);
    idle_for(7);
    send_request(scba_pkg::OP_FREE, 16'hFFFF, 17'd8);
    send_request(scba_pkg::OP_FREE, 16'd0, 17'd8);
    send_request(scba_pkg::OP_FREE, 16'd0, 17'd8);
    // A class 1 block freed with a class 0 size lands on the class 0 list.
    send_request(scba_pkg::OP_FREE, 16'd0, 17'd40);
    send_request(scba_pkg::OP_ALLOC, 16'd0, 17'd0);
    send_request(scba_pkg::OP_ALLOC, 16'd0, 17'd0);
    send_request(scba_pkg::OP_NONE, 16'hFFFF, 17'h1FFFF);
    send_request(scba_pkg::OP_FREE, 16'd32696, 17'd72);
    send_request(scba_pkg::OP_ALLOC, 16'd16376, 17'd0);
    send_request(scba_pkg::OP_ALLOC, 16'd32000, 17'd0);
    drain_replies();

    for (int n = 0; n < RandomRequests; n++) begin
      issue_random_request();
      if (n % 200 == 199) drain_replies();
    end

    // Use up the bump space, then recycle through the lists.
    repeat (8) send_request(scba_pkg::OP_ALLOC, 16'd32696, 17'd0);
    repeat (30) issue_random_request();

    drain_replies();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && outstanding_count == 0) begin
      $display("size_class_block_allocator_top_tb: done, clean");
    end else begin
      $display("size_class_block_allocator_top_tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/scba_pkg.sv
rtl/scba_ram.sv
rtl/scba_ctrl.sv
rtl/scba_dpath.sv
rtl/size_class_block_allocator_top.sv
bench/size_class_block_allocator_checker.sv
bench/size_class_block_allocator_top_tb.sv
